// ===== design/sfcd_pkg.sv =====
`default_nettype none
package sfcd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [3:0] FRAME_LAST = 4'd8;

  localparam logic [14:0] TEMP_SCALE = 15'd17500;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
  localparam logic [13:0] HUMID_SCALE = 14'd10000;

  // one completed frame, raw words and per-group crc results
  typedef struct packed {
    logic [15:0] co2_word;
    logic [15:0] temp_word;
    logic [15:0] humid_word;
    logic        co2_ok;
    logic        temp_ok;
    logic        humid_ok;
  } frame_t;

  // crc-8, msb first, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/sfcd_if.sv =====
`default_nettype none
interface sfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcd_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        co2_ppm;
  logic               co2_valid;
  logic signed [14:0] temp_centi;
  logic               temp_valid;
  logic [13:0]        humid_centi;
  logic               humid_valid;
  logic               frame_ok;

  modport source (output valid, output co2_ppm, output co2_valid, output temp_centi,
                  output temp_valid, output humid_centi, output humid_valid,
                  output frame_ok, input ready);
  modport sink (input valid, input co2_ppm, input co2_valid, input temp_centi,
                input temp_valid, input humid_centi, input humid_valid,
                input frame_ok, output ready);
endinterface
`default_nettype wire

// ===== design/sfcd_frame_parse.sv =====
`default_nettype none
module sfcd_frame_parse
  import sfcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_start,
  output frame_t          frame,
  output logic            frame_done
);

  logic [3:0]  pos;
  logic [7:0]  crc;
  logic [15:0] group_word;
  logic [15:0] co2_word;
  logic [15:0] temp_word;
  logic [2:0]  flags;

  logic [3:0]  pos_eff;
  logic [2:0]  flags_base;
  logic [3:0]  pos_next;
  logic [7:0]  crc_next;
  logic [15:0] group_word_next;
  logic [15:0] co2_word_next;
  logic [15:0] temp_word_next;
  logic [2:0]  flags_next;
  logic        good;

  always_comb begin
    pos_eff = (frame_start || pos > FRAME_LAST) ? 4'd0 : pos;
    flags_base = (pos_eff == 4'd0) ? 3'b000 : flags;
    good = (crc == rx_byte);

    crc_next = crc;
    group_word_next = group_word;
    co2_word_next = co2_word;
    temp_word_next = temp_word;
    flags_next = flags_base;

    case (pos_eff) inside
      4'd0, 4'd3, 4'd6: begin
        crc_next = crc8_byte(CRC_INIT, rx_byte);
        group_word_next = {rx_byte, 8'h00};
      end
      4'd1, 4'd4, 4'd7: begin
        crc_next = crc8_byte(crc, rx_byte);
        group_word_next = {group_word[15:8], rx_byte};
      end
      4'd2: begin
        flags_next[0] = flags_base[0] | good;
        co2_word_next = good ? group_word : 16'h0000;
      end
      4'd5: begin
        flags_next[1] = flags_base[1] | good;
        temp_word_next = good ? group_word : 16'h0000;
      end
      default: begin
        flags_next[2] = flags_base[2] | good;
      end
    endcase

    pos_next = (pos_eff == FRAME_LAST) ? 4'd0 : pos_eff + 4'd1;

    frame_done = accept && (pos_eff == FRAME_LAST);
    frame.co2_word = co2_word;
    frame.temp_word = temp_word;
    frame.humid_word = group_word;
    frame.co2_ok = flags_base[0];
    frame.temp_ok = flags_base[1];
    frame.humid_ok = good;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 4'd0;
      crc <= CRC_INIT;
      group_word <= 16'h0000;
      co2_word <= 16'h0000;
      temp_word <= 16'h0000;
      flags <= 3'b000;
    end else if (accept) begin
      pos <= pos_next;
      crc <= crc_next;
      group_word <= group_word_next;
      co2_word <= co2_word_next;
      temp_word <= temp_word_next;
      flags <= flags_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= FRAME_LAST)
    else $error("frame position out of range");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |=> pos == 4'd1)
    else $error("start mark did not restart the frame");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> pos == 4'd0)
    else $error("position did not wrap after last byte");

endmodule
`default_nettype wire

// ===== design/sensor_frame_crc_decoder.sv =====
// Sensor measurement frame decoder with per-group CRC-8 check.
//
// rx channel: one response byte per transfer, frame_start marks byte 0 of a
// nine-byte frame (a byte at position 0 counts as byte 0 even without it).
// Each group of three bytes is a 16-bit word, high byte first, and its CRC-8
// (poly 0x31, init 0xFF). meas channel: one transfer per completed frame with
// the CO2 word, temperature and humidity in hundredths, a valid flag per
// word (failed words read zero) and frame_ok when all three groups passed.
//
// Throughput: one byte per cycle while rx.ready is high; the CRC update of a
// byte is combinational logic. The frame register loads at the ninth byte
// transfer, then the scaling multipliers feed the output register.
//
// Reset empties both stages, clears the frame position, sets the CRC to 0xFF.
// When meas stalls, the output register holds; the frame register behind it
// still takes one more frame, and rx.ready drops only once both are full.
`default_nettype none
module sensor_frame_crc_decoder
  import sfcd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sfcd_in_if.sink   rx,
  sfcd_out_if.source meas
);

  frame_t frame;
  logic   frame_done;
  logic   rx_accept;

  frame_t a_frame;
  logic   a_valid;
  logic   out_adv;
  logic   a_adv;

  logic [30:0]        temp_prod;
  logic [29:0]        humid_prod;
  logic signed [15:0] temp_full;

  assign out_adv = !meas.valid || meas.ready;
  assign a_adv = !a_valid || out_adv;
  assign rx.ready = a_adv;
  assign rx_accept = rx.valid && rx.ready;

  sfcd_frame_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (rx_accept),
    .rx_byte    (rx.rx_byte),
    .frame_start(rx.frame_start),
    .frame      (frame),
    .frame_done (frame_done)
  );

  // frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && frame_done) begin
      a_frame <= frame;
    end
  end

  // fixed-point scaling, floor by dropping 16 fraction bits
  always_comb begin
    temp_prod = 31'(TEMP_SCALE) * 31'(a_frame.temp_word);
    humid_prod = 30'(HUMID_SCALE) * 30'(a_frame.humid_word);
    temp_full = $signed({1'b0, temp_prod[30:16]}) - TEMP_OFFSET;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      meas.valid <= 1'b0;
    end else if (out_adv) begin
      meas.valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && a_valid) begin
      meas.co2_ppm <= a_frame.co2_ok ? a_frame.co2_word : 16'h0000;
      meas.co2_valid <= a_frame.co2_ok;
      meas.temp_centi <= a_frame.temp_ok ? temp_full[14:0] : 15'sd0;
      meas.temp_valid <= a_frame.temp_ok;
      meas.humid_centi <= a_frame.humid_ok ? humid_prod[29:16] : 14'd0;
      meas.humid_valid <= a_frame.humid_ok;
      meas.frame_ok <= a_frame.co2_ok && a_frame.temp_ok && a_frame.humid_ok;
    end
  end

  a_stage_kept: assert property (@(posedge clk) disable iff (rst)
    a_valid && !out_adv |=> a_valid)
    else $error("frame register dropped a frame under stall");

  a_temp_zero: assert property (@(posedge clk) disable iff (rst)
    meas.valid && !meas.temp_valid |-> meas.temp_centi == 15'sd0)
    else $error("failed temperature word not zero");

  a_ok_flags: assert property (@(posedge clk) disable iff (rst)
    meas.valid |-> meas.frame_ok == (meas.co2_valid && meas.temp_valid && meas.humid_valid))
    else $error("frame_ok disagrees with group flags");

endmodule
`default_nettype wire
